### rtl/ssrs_pkg.sv
package ssrs_pkg;

   // field and register widths
   localparam int OFFSET_BITS = 40;
   localparam int SECTOR_W    = 16;
   localparam int LENGTH_W    = 16;
   localparam int CHUNK_W     = 15;
   localparam int POSITION_W  = 14;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = OFFSET_BITS;

   // request limits
   localparam int MAX_REQUEST = 16384;
   localparam int MIN_PAYLOAD = 512;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_BYTES     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_SECTOR_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_BYTES     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PAYLOAD_BYTES    = 2'd3;

   // register reset values
   localparam logic [OFFSET_BITS-1:0] RESET_SOURCE_BYTES     = '0;
   localparam logic [SECTOR_W-1:0]    RESET_RAW_SECTOR_BYTES = 16'd2352;
   localparam logic [SECTOR_W-1:0]    RESET_HEADER_BYTES     = 16'd16;
   localparam logic [SECTOR_W-1:0]    RESET_PAYLOAD_BYTES    = 16'd2048;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_CHUNK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] logical_offset;
      logic [LENGTH_W-1:0]    request_length;
   } req_payload_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] raw_offset;
      logic [CHUNK_W-1:0]     chunk_length;
      logic [POSITION_W-1:0]  result_position;
      logic [STATUS_W-1:0]    status;
      logic                   last_chunk;
   } rsp_payload_type;

endpackage

### rtl/stripped_sector_read_splitter_core.sv
// Channel   Ports                                  Transfer when
// request   req_valid, req_stall, req_payload      req_valid high, req_stall low
// result    rsp_valid, rsp_stall, rsp_payload      rsp_valid high, rsp_stall low
// config    csr_write_enable, csr_index, csr_write_data  csr_write_enable high
//
// A request over the length limit goes from idle to the status-only state, which
// loads its single result into the output register. Any other request first runs
// two bit-serial dividers side by side, one quotient bit each step, then two
// shift-add multipliers side by side, one multiplier bit each step, then totals
// and clips; then one result per cycle while rsp_stall is low, up to 33 in all.
// Reset is synchronous and restores the register defaults; results wait in an
// output register under rsp_stall, and a new request is taken once the last
// result of the previous one is loaded there.
module stripped_sector_read_splitter_core
   import ssrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_W   = $clog2(OFFSET_BITS);
   localparam int PROD_W  = OFFSET_BITS + SECTOR_W;
   localparam int TOTAL_W = PROD_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_TOTAL  = 3'd3;
   localparam logic [2:0] ST_CLIP   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;
   localparam logic [2:0] ST_SINGLE = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [OFFSET_BITS-1:0] src_ff, src_in;
   logic [SECTOR_W-1:0]    raw_ff, raw_in;
   logic [SECTOR_W-1:0]    hdr_ff, hdr_in;
   logic [SECTOR_W-1:0]    pay_ff, pay_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LENGTH_W-1:0]    length_ff, length_in;
   logic [OFFSET_BITS-1:0] qa_ff, qa_in;
   logic [SECTOR_W-1:0]    ra_ff, ra_in;
   logic [OFFSET_BITS-1:0] qb_ff, qb_in;
   logic [SECTOR_W-1:0]    rb_ff, rb_in;
   logic [PROD_W-1:0]      ma_ff, ma_in;
   logic [OFFSET_BITS-1:0] mb_ff, mb_in;
   logic [SECTOR_W-1:0]    pay_sh_ff, pay_sh_in;
   logic [SECTOR_W-1:0]    raw_sh_ff, raw_sh_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [CHUNK_W-1:0]     left_ff, left_in;
   logic [CHUNK_W-1:0]     done_ff, done_in;
   logic [SECTOR_W-1:0]    within_ff, within_in;
   logic [OFFSET_BITS-1:0] base_ff, base_in;
   logic [STATUS_W-1:0]    single_ff, single_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   out_free;
   logic [SECTOR_W:0]      a_sh, a_sub, b_sh, b_sub;
   logic                   a_ge, b_ge;
   logic [SECTOR_W-1:0]    part;
   logic [SECTOR_W-1:0]    part_min;
   logic                   bad_geometry;
   logic [TOTAL_W-1:0]     offset_wide;
   logic [TOTAL_W-1:0]     avail;
   logic [SECTOR_W-1:0]    room;
   logic [CHUNK_W-1:0]     take;
   logic                   last_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // one restoring division step per divider
   assign a_sh  = {ra_ff, qa_ff[OFFSET_BITS-1]};
   assign a_sub = a_sh - {1'b0, raw_ff};
   assign a_ge  = (a_sh >= {1'b0, raw_ff});
   assign b_sh  = {rb_ff, qb_ff[OFFSET_BITS-1]};
   assign b_sub = b_sh - {1'b0, pay_ff};
   assign b_ge  = (b_sh >= {1'b0, pay_ff});

   // partial last sector and geometry check
   assign bad_geometry = (raw_ff == '0) || (pay_ff < SECTOR_W'(MIN_PAYLOAD));
   assign part         = ra_ff - hdr_ff;
   assign part_min     = (part < pay_ff) ? part : pay_ff;

   // clip against the end of the stripped space
   assign offset_wide = {{(TOTAL_W-OFFSET_BITS){1'b0}}, offset_ff};
   assign avail       = total_ff - offset_wide;

   // chunk sizing for the current sector
   assign room      = pay_ff - within_ff;
   assign take      = ({1'b0, room} < {{(SECTOR_W+1-CHUNK_W){1'b0}}, left_ff})
                      ? room[CHUNK_W-1:0] : left_ff;
   assign last_take = (take == left_ff);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      src_in         = src_ff;
      raw_in         = raw_ff;
      hdr_in         = hdr_ff;
      pay_in         = pay_ff;
      offset_in      = offset_ff;
      length_in      = length_ff;
      qa_in          = qa_ff;
      ra_in          = ra_ff;
      qb_in          = qb_ff;
      rb_in          = rb_ff;
      ma_in          = ma_ff;
      mb_in          = mb_ff;
      pay_sh_in      = pay_sh_ff;
      raw_sh_in      = raw_sh_ff;
      total_in       = total_ff;
      left_in        = left_ff;
      done_in        = done_ff;
      within_in      = within_ff;
      base_in        = base_ff;
      single_in      = single_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      // register writes
      if (csr_write_enable) begin
         case (csr_index)
            REG_SOURCE_BYTES:     src_in = csr_write_data[OFFSET_BITS-1:0];
            REG_RAW_SECTOR_BYTES: raw_in = csr_write_data[SECTOR_W-1:0];
            REG_HEADER_BYTES:     hdr_in = csr_write_data[SECTOR_W-1:0];
            REG_PAYLOAD_BYTES:    pay_in = csr_write_data[SECTOR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // take a request and load both dividers
            if (req_valid) begin
               offset_in = req_payload.logical_offset;
               length_in = req_payload.request_length;
               qa_in     = src_ff;
               ra_in     = '0;
               qb_in     = req_payload.logical_offset;
               rb_in     = '0;
               cnt_in    = '0;
               if (req_payload.request_length > LENGTH_W'(MAX_REQUEST)) begin
                  single_in = STATUS_TOO_LONG;
                  state_in  = ST_SINGLE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // shift in one quotient bit on each divider
            qa_in  = {qa_ff[OFFSET_BITS-2:0], a_ge};
            ra_in  = a_ge ? a_sub[SECTOR_W-1:0] : a_sh[SECTOR_W-1:0];
            qb_in  = {qb_ff[OFFSET_BITS-2:0], b_ge};
            rb_in  = b_ge ? b_sub[SECTOR_W-1:0] : b_sh[SECTOR_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OFFSET_BITS - 1)) begin
               cnt_in    = '0;
               ma_in     = '0;
               mb_in     = '0;
               pay_sh_in = pay_ff;
               raw_sh_in = raw_ff;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add one multiplier bit per cycle, most significant first
            ma_in = {ma_ff[PROD_W-2:0], 1'b0}
                    + (pay_sh_ff[SECTOR_W-1] ? {{SECTOR_W{1'b0}}, qa_ff} : '0);
            mb_in = {mb_ff[OFFSET_BITS-2:0], 1'b0}
                    + (raw_sh_ff[SECTOR_W-1] ? qb_ff : '0);
            pay_sh_in = {pay_sh_ff[SECTOR_W-2:0], 1'b0};
            raw_sh_in = {raw_sh_ff[SECTOR_W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SECTOR_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            // whole sectors plus the partial last one, or zero for a bad geometry
            if (bad_geometry) begin
               total_in = '0;
            end else if (ra_ff > hdr_ff) begin
               total_in = {1'b0, ma_ff} + {{(TOTAL_W-SECTOR_W){1'b0}}, part_min};
            end else begin
               total_in = {1'b0, ma_ff};
            end
            base_in  = mb_ff + {{(OFFSET_BITS-SECTOR_W){1'b0}}, hdr_ff};
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            // drop empty or past-end requests, clip the rest
            if ((length_ff == '0) || (offset_wide >= total_ff)) begin
               single_in = STATUS_EMPTY;
               state_in  = ST_SINGLE;
            end else begin
               if (avail < {{(TOTAL_W-LENGTH_W){1'b0}}, length_ff}) begin
                  left_in = avail[CHUNK_W-1:0];
               end else begin
                  left_in = length_ff[CHUNK_W-1:0];
               end
               done_in   = '0;
               within_in = rb_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hand out one chunk per sector
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.raw_offset      = base_ff
                  + {{(OFFSET_BITS-SECTOR_W){1'b0}}, within_ff};
               rsp_payload_in.chunk_length    = take;
               rsp_payload_in.result_position = done_ff[POSITION_W-1:0];
               rsp_payload_in.status          = STATUS_CHUNK;
               rsp_payload_in.last_chunk      = last_take;
               done_in   = done_ff + take;
               left_in   = left_ff - take;
               within_in = '0;
               base_in   = base_ff + {{(OFFSET_BITS-SECTOR_W){1'b0}}, raw_ff};
               if (last_take) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SINGLE: begin
            // one status-only result
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.raw_offset      = '0;
               rsp_payload_in.chunk_length    = '0;
               rsp_payload_in.result_position = '0;
               rsp_payload_in.status          = single_ff;
               rsp_payload_in.last_chunk      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         src_ff       <= RESET_SOURCE_BYTES;
         raw_ff       <= RESET_RAW_SECTOR_BYTES;
         hdr_ff       <= RESET_HEADER_BYTES;
         pay_ff       <= RESET_PAYLOAD_BYTES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         raw_ff       <= raw_in;
         hdr_ff       <= hdr_in;
         pay_ff       <= pay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff      <= offset_in;
      length_ff      <= length_in;
      qa_ff          <= qa_in;
      ra_ff          <= ra_in;
      qb_ff          <= qb_in;
      rb_ff          <= rb_in;
      ma_ff          <= ma_in;
      mb_ff          <= mb_in;
      pay_sh_ff      <= pay_sh_in;
      raw_sh_ff      <= raw_sh_in;
      total_ff       <= total_in;
      left_ff        <= left_in;
      done_ff        <= done_in;
      within_ff      <= within_in;
      base_ff        <= base_in;
      single_ff      <= single_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // a chunk result always carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.status == STATUS_CHUNK)
      |-> (rsp_payload_ff.chunk_length != '0))
      else $error("chunk result with zero length");

   // status-only results are single and final
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.status != STATUS_CHUNK)
      |-> rsp_payload_ff.last_chunk && (rsp_payload_ff.chunk_length == '0))
      else $error("status result not final or not empty");

   // bytes remain while chunks are being emitted
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (left_ff != '0))
      else $error("emit with nothing left");

   // the final chunk returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free && last_take |=> (state_ff == ST_IDLE))
      else $error("no return to idle after final chunk");

endmodule
